// ----- hdl/mrfb_pkg.sv -----
package mrfb_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // command queue between front and back
    localparam int QDEPTH = 2;

    // byte slots of one command, sent lowest index first
    localparam int SLOT_ADDR  = 0;
    localparam int SLOT_FUNC  = 1;
    localparam int SLOT_DATA  = 2;
    localparam int SLOT_CRCLO = 3;
    localparam int SLOT_CRCHI = 4;
    localparam int NSLOTS     = 5;

    typedef logic [NSLOTS-1:0] slot_mask_t;

    typedef struct packed {
        logic       start;
        logic [7:0] func;
        logic       emit_data;
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } cmd_t;

    // reflected CRC-16, one byte folded in
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/mrfb_if.sv -----
interface mrfb_item_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] function_code;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, frame_start, function_code, has_byte, data_byte, frame_last,
                    input ready);
    modport sink   (input valid, frame_start, function_code, has_byte, data_byte, frame_last,
                    output ready);
endinterface

interface mrfb_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       overflow;

    modport source (output valid, out_byte, frame_end, overflow, input ready);
    modport sink   (input valid, out_byte, frame_end, overflow, output ready);
endinterface

interface mrfb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/mrfb_front.sv -----
module mrfb_front #(
    parameter int MAX_PAYLOAD = 252
) (
    input  logic          clk,
    input  logic          rst_n,
    mrfb_item_if.sink     item,
    output logic          push,
    output mrfb_pkg::cmd_t push_cmd,
    input  logic          full
);
    import mrfb_pkg::*;

    localparam int CntW = $clog2(MAX_PAYLOAD + 1);

    logic [CntW-1:0] cnt_reg, cnt_next, cnt_base;
    logic            ovf_reg, ovf_next, ovf_base, ovf_item;
    logic            take_data;

    assign item.ready = !full;
    assign push       = item.valid && item.ready;

    always_comb
    begin
        cnt_base  = item.frame_start ? '0 : cnt_reg;
        ovf_base  = item.frame_start ? 1'b0 : ovf_reg;
        take_data = item.has_byte && (cnt_base < CntW'(MAX_PAYLOAD));
        // bytes past the limit are dropped and flagged
        ovf_item  = ovf_base | (item.has_byte & ~take_data);

        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (push)
        begin
            if (item.frame_last)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_base + CntW'(take_data);
                ovf_next = ovf_item;
            end
        end

        push_cmd.start     = item.frame_start;
        push_cmd.func      = item.function_code;
        push_cmd.emit_data = take_data;
        push_cmd.data      = item.data_byte;
        push_cmd.last      = item.frame_last;
        push_cmd.ovf       = ovf_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// ----- hdl/mrfb_queue.sv -----
module mrfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrfb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output mrfb_pkg::cmd_t head,
    output logic           empty
);
    import mrfb_pkg::*;

    localparam int PtrW = $clog2(QDEPTH);
    localparam int CntW = $clog2(QDEPTH + 1);

    cmd_t            mem [QDEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full  = (count_reg == CntW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/mrfb_back.sv -----
module mrfb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     slave_address,
    input  mrfb_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    mrfb_result_if.source  result
);
    import mrfb_pkg::*;

    cmd_t       cur_reg, cur_next;
    slot_mask_t mask_reg, mask_next, mask_left;
    logic [15:0] crc_reg, crc_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        oend_reg, oend_next;
    logic        oovf_reg, oovf_next;
    logic        can_emit, emit;

    assign result.valid     = ovalid_reg;
    assign result.out_byte  = obyte_reg;
    assign result.frame_end = oend_reg;
    assign result.overflow  = oovf_reg;

    always_comb
    begin
        can_emit    = !ovalid_reg || result.ready;
        emit        = can_emit && (mask_reg != '0);
        mask_left   = mask_reg;
        crc_next    = crc_reg;
        ovalid_next = ovalid_reg && !result.ready;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;
        oovf_next   = oovf_reg;

        if (emit)
        begin
            ovalid_next = 1'b1;
            oend_next   = 1'b0;
            oovf_next   = cur_reg.ovf;
            priority if (mask_reg[SLOT_ADDR])
            begin
                // address opens the frame: checksum restarts here
                obyte_next           = slave_address;
                oovf_next            = 1'b0;
                crc_next             = crc_fold(CRC_INIT, slave_address);
                mask_left[SLOT_ADDR] = 1'b0;
            end
            else if (mask_reg[SLOT_FUNC])
            begin
                obyte_next           = cur_reg.func;
                oovf_next            = 1'b0;
                crc_next             = crc_fold(crc_reg, cur_reg.func);
                mask_left[SLOT_FUNC] = 1'b0;
            end
            else if (mask_reg[SLOT_DATA])
            begin
                obyte_next           = cur_reg.data;
                crc_next             = crc_fold(crc_reg, cur_reg.data);
                mask_left[SLOT_DATA] = 1'b0;
            end
            else if (mask_reg[SLOT_CRCLO])
            begin
                obyte_next            = crc_reg[7:0];
                mask_left[SLOT_CRCLO] = 1'b0;
            end
            else
            begin
                obyte_next            = crc_reg[15:8];
                oend_next             = 1'b1;
                crc_next              = CRC_INIT;
                mask_left[SLOT_CRCHI] = 1'b0;
            end
        end

        // next request loads as the current one sends its final byte
        pop       = (mask_left == '0) && !empty;
        mask_next = mask_left;
        cur_next  = cur_reg;
        if (pop)
        begin
            cur_next              = head;
            mask_next[SLOT_ADDR]  = head.start;
            mask_next[SLOT_FUNC]  = head.start;
            mask_next[SLOT_DATA]  = head.emit_data;
            mask_next[SLOT_CRCLO] = head.last;
            mask_next[SLOT_CRCHI] = head.last;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
        oovf_reg  <= oovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            crc_reg    <= CRC_INIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            mask_reg   <= mask_next;
            crc_reg    <= crc_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- hdl/modbus_rtu_frame_builder_core.sv -----
// A request passes through the command queue and the back-end command register before its first
// byte is registered onto result. The back end sends one frame byte per cycle while result is
// ready; a request produces up to five bytes, or none.
// The front takes a request per cycle while the two-entry command queue has room.
// Reset (rst_n low, asynchronous): queue emptied, CRC 0xFFFF, counts cleared,
// slave address 1.
module modbus_rtu_frame_builder_core #(
    parameter int MAX_PAYLOAD = 252
) (
    input  logic          clk,
    input  logic          rst_n,
    mrfb_item_if.sink     item,
    mrfb_result_if.source result,
    mrfb_cfg_if.sink      cfg
);
    import mrfb_pkg::*;

    logic [7:0] slave_addr_reg, slave_addr_next;
    logic       push, pop, full, empty;
    cmd_t       push_cmd, head;

    assign cfg.ready       = 1'b1;
    assign slave_addr_next = (cfg.valid && cfg.ready) ? cfg.data : slave_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
        end
        else
        begin
            slave_addr_reg <= slave_addr_next;
        end
    end

    mrfb_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    mrfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    mrfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (slave_addr_reg),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule

// ----- hdl/mrfb_checker.sv -----
module mrfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_byte,
    input logic       res_end,
    input logic       res_ovf
);
    logic res_acc;
    logic seen_reg;
    logic last_end_reg;
    logic last_ovf_reg;

    assign res_acc = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_end_reg <= 1'b0;
            last_ovf_reg <= 1'b0;
        end
        else if (res_acc)
        begin
            seen_reg     <= 1'b1;
            last_end_reg <= res_end;
            last_ovf_reg <= res_ovf;
        end
    end

    // stalled request holds its bytes
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_end)
            && $stable(res_ovf))
        else $error("result changed while stalled");

    // CRC high byte always follows the low byte of the same frame
    a_lo_first: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && res_end |-> seen_reg && !last_end_reg)
        else $error("frame end without preceding CRC low byte");

    // both CRC bytes carry the same overflow mark
    a_ovf_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && res_end |-> res_ovf == last_ovf_reg)
        else $error("overflow differs across CRC bytes");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

endmodule

bind modbus_rtu_frame_builder_core mrfb_checker u_mrfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_byte  (result.out_byte),
    .res_end   (result.frame_end),
    .res_ovf   (result.overflow)
);

// ----- bench/tb_modbus_rtu_frame_builder_core.sv -----
module tb_modbus_rtu_frame_builder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mrfb_pkg::*;

    localparam int PAYLOAD_LIMIT = 252;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 90;
    localparam int DRAIN_CAP     = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic       start;
        logic [7:0] func;
        logic       has;
        logic [7:0] data;
        logic       last;
    } request_t;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       overflow;
    } line_byte_t;

    // Tracks the frame under construction and the line bytes it should produce.
    class frame_tracker;
        logic [15:0] crc_table [256];
        logic [7:0]  station;
        logic [15:0] crc;
        int unsigned payload_len;
        logic        dropped;
        line_byte_t  pending_bytes[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            logic [15:0] v;
            for (int i = 0; i < 256; i++)
            begin
                v = 16'(i);
                for (int k = 0; k < 8; k++)
                begin
                    if (v[0])
                        v = (v >> 1) ^ CRC_POLY;
                    else
                        v = v >> 1;
                end
                crc_table[i] = v;
            end
            station     = 8'h01;
            mismatches  = 0;
            checked     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc         = CRC_INIT;
            payload_len = 0;
            dropped     = 1'b0;
        endfunction

        // table-driven, low byte first (reflected)
        function void fold(input logic [7:0] b);
            crc = (crc >> 8) ^ crc_table[crc[7:0] ^ b];
        endfunction

        function void queue_byte(input logic [7:0] v, input logic e, input logic o);
            line_byte_t lb;
            lb.value     = v;
            lb.frame_end = e;
            lb.overflow  = o;
            pending_bytes.push_back(lb);
        endfunction

        function void note_request(input request_t r);
            if (r.start)
            begin
                clear_frame();
                fold(station);
                queue_byte(station, 1'b0, 1'b0);
                fold(r.func);
                queue_byte(r.func, 1'b0, 1'b0);
            end
            if (r.has)
            begin
                if (payload_len < PAYLOAD_LIMIT)
                begin
                    fold(r.data);
                    payload_len++;
                    queue_byte(r.data, 1'b0, dropped);
                end
                else
                    dropped = 1'b1;
            end
            if (r.last)
            begin
                queue_byte(crc[7:0], 1'b0, dropped);
                queue_byte(crc[15:8], 1'b1, dropped);
                clear_frame();
            end
        endfunction

        task report(input string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_line_byte(input logic [7:0] v, input logic e, input logic o);
            line_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("byte %02h arrived with nothing outstanding", v));
                return;
            end
            want = pending_bytes.pop_front();
            if (v !== want.value)
                report($sformatf("byte #%0d out_byte %02h, want %02h", checked, v, want.value));
            if (e !== want.frame_end)
                report($sformatf("byte #%0d frame_end %b, want %b", checked, e, want.frame_end));
            if (o !== want.overflow)
                report($sformatf("byte #%0d overflow %b, want %b", checked, o, want.overflow));
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    mrfb_item_if   item_ch ();
    mrfb_result_if result_ch ();
    mrfb_cfg_if    cfg_ch ();

    modbus_rtu_frame_builder_core #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .cfg(cfg_ch)
    );

    frame_tracker tracker = new();
    int unsigned  cycle_count = 0;
    int unsigned  requests_sent = 0;
    int unsigned  tx_idle_pct = 32;
    int unsigned  rx_idle_pct = 45;
    bit           hold_request = 1'b0;
    logic [7:0]   last_station;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("timed out after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: checks accepted bytes, random back-pressure, one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                tracker.check_line_byte(result_ch.out_byte, result_ch.frame_end,
                                        result_ch.overflow);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic request_t mk_request(input logic s, input logic [7:0] f, input logic h,
                                            input logic [7:0] d, input logic l);
        request_t r;
        r.start = s;
        r.func  = f;
        r.has   = h;
        r.data  = d;
        r.last  = l;
        return r;
    endfunction

    function automatic request_t random_request();
        return mk_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
    endfunction

    // called on a clock edge; returns on the edge the request is taken
    task automatic send_request(input request_t r);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        item_ch.valid         <= 1'b1;
        item_ch.frame_start   <= r.start;
        item_ch.function_code <= r.func;
        item_ch.has_byte      <= r.has;
        item_ch.data_byte     <= r.data;
        item_ch.frame_last    <= r.last;
        do
            @(posedge clk);
        while (!item_ch.ready);
        tracker.note_request(r);
        requests_sent++;
    endtask

    // drop valid, let every expected byte out, then wait out SETTLE_CYCLES for
    // requests that produce nothing
    task automatic quiesce();
        int spins;
        spins = 0;
        item_ch.valid <= 1'b0;
        while (tracker.pending_bytes.size() != 0 && spins < DRAIN_CAP)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_station(input logic [7:0] addr);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= addr;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tracker.station = addr;
        last_station = addr;
    endtask

    // mostly well-formed frames with random content, some unclosed, some noise
    task automatic run_traffic(input int unsigned budget);
        int unsigned done_n;
        int unsigned pick;
        int unsigned len;
        request_t    r;
        done_n = 0;
        while (done_n < budget)
        begin
            pick = $urandom_range(99);
            r = random_request();
            if (pick < 15)
            begin
                send_request(r);
                done_n++;
            end
            else
            begin
                r.start = 1'b1;
                r.last  = ($urandom_range(9) == 0);
                send_request(r);
                done_n++;
                if (!r.last)
                begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(6);
                    repeat (len)
                    begin
                        r = random_request();
                        r.start = 1'b0;
                        r.has   = 1'b1;
                        r.last  = 1'b0;
                        send_request(r);
                        done_n++;
                    end
                    // frames drawn with pick below 25 are left open
                    if (pick >= 25)
                    begin
                        r = random_request();
                        r.start = 1'b0;
                        r.last  = 1'b1;
                        send_request(r);
                        done_n++;
                    end
                end
            end
        end
    endtask

    task automatic long_frame(input int unsigned payload);
        send_request(mk_request(1'b1, 8'($urandom_range(255)), 1'b0, 8'h00, 1'b0));
        repeat (payload)
            send_request(mk_request(1'b0, 8'($urandom_range(255)), 1'b1,
                                    8'($urandom_range(255)), 1'b0));
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'($urandom_range(255)), 1'b1));
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.frame_start   <= 1'b0;
        item_ch.function_code <= 8'h00;
        item_ch.has_byte      <= 1'b0;
        item_ch.data_byte     <= 8'h00;
        item_ch.frame_last    <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.data           <= 8'h00;
        last_station = 8'h01;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset station address
        send_request(mk_request(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));  // close with nothing folded
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'h00, 1'b0));  // byte with no start
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'hFF, 1'b1));
        send_request(mk_request(1'b1, 8'h03, 1'b0, 8'h00, 1'b0));  // read holding regs
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'h00, 1'b0));
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'h6B, 1'b0));
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'h00, 1'b0));
        send_request(mk_request(1'b0, 8'h00, 1'b1, 8'h03, 1'b1));
        send_request(mk_request(1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1));  // all five bytes
        send_request(mk_request(1'b1, 8'h00, 1'b1, 8'h00, 1'b1));
        send_request(mk_request(1'b0, 8'hFF, 1'b0, 8'hFF, 1'b0));  // no effect
        send_request(mk_request(1'b1, 8'h10, 1'b1, 8'hAA, 1'b0));
        send_request(mk_request(1'b1, 8'h06, 1'b0, 8'h55, 1'b0));  // restart, drops the open frame
        send_request(mk_request(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
        send_request(mk_request(1'b1, 8'h80, 1'b0, 8'h00, 1'b1));
        send_request(mk_request(1'b0, 8'hA5, 1'b1, 8'h5A, 1'b0));
        send_request(mk_request(1'b1, 8'h01, 1'b1, 8'h01, 1'b0));
        send_request(mk_request(1'b0, 8'h00, 1'b0, 8'h00, 1'b1));

        quiesce();
        write_station(8'hFF);
        run_traffic(40);
        hold_request = 1'b1;        // sender keeps offering into the stall
        run_traffic(40);
        quiesce();
        run_traffic(20);

        quiesce();
        write_station(8'h00);
        tx_idle_pct = 45;
        rx_idle_pct = 32;
        run_traffic(60);

        quiesce();
        write_station(8'($urandom_range(255)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_frame(PAYLOAD_LIMIT + 2);  // runs past the payload limit
        run_traffic(40);

        quiesce();
        if (tracker.pending_bytes.size() != 0)
            tracker.report($sformatf("%0d bytes never arrived", tracker.pending_bytes.size()));

        $display("%0d requests, %0d frame bytes compared, %0d mismatches",
                 requests_sent, tracker.checked, tracker.mismatches);
        $display("stations 01/FF/00/%02h, back-pressure and a frame over the payload limit",
                 last_station);
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
